// File: src/packet_ring_fifo_defines.svh
// ---------------------------------------------------------------------------
// packet_ring_fifo assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef PACKET_RING_FIFO_DEFINES_SVH
`define PACKET_RING_FIFO_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PRF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet_ring_fifo assertion failed");
// next-cycle implication
`define PRF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet_ring_fifo assertion failed");
`else
`define PRF_ASSERT_IMP(label, clk, rst, ante, cons)
`define PRF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/prf_pkg.sv
// ---------------------------------------------------------------------------
// prf_pkg
// shared constants, codes and types of the packet ring fifo
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prf_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 8;
   localparam int unsigned SLOT_BYTES_DEF = 512;

   localparam int unsigned DATA_W         = 64;
   localparam int unsigned BYTES_PER_WORD = 8;
   localparam int unsigned NB_W           = 4;   // byte count of one beat
   localparam int unsigned LEN_W          = 10;  // packet length in bytes
   localparam int unsigned WCNT_W         = 7;   // word count of one packet
   localparam int unsigned MIN_W          = 9;
   localparam int unsigned CNT_W          = 32;

   localparam logic [MIN_W-1:0] MIN_BYTES_RST = 9'd16;

   // request codes
   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REJECT   = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN  = 2'd2;
   localparam logic [1:0] STATUS_UNDERRUN = 2'd3;

   // staging state as seen after the current push beat
   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic              too_long;
      logic [DATA_W-1:0] tail;
   } pack_stat_type;

   // completed staging word to be stored
   typedef struct packed {
      logic              en;
      logic [WCNT_W-1:0] index;
      logic [DATA_W-1:0] word;
   } word_wr_type;

   // mask of the low nbytes bytes of a word
   function automatic logic [DATA_W-1:0] byte_mask(input logic [NB_W-1:0] nbytes);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         if (NB_W'(i) < nbytes) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

// File: src/prf_ram.sv
// ---------------------------------------------------------------------------
// prf_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prf_ram #(
   parameter int unsigned WIDTH = prf_pkg::DATA_W,
   parameter int unsigned DEPTH = prf_pkg::SLOT_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/prf_pack.sv
// ---------------------------------------------------------------------------
// prf_pack
// byte packer: folds push beats into contiguous staging words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prf_pack #(
   parameter int unsigned SLOT_BYTES = prf_pkg::SLOT_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_en,
   input  logic                          drop,
   input  logic [prf_pkg::DATA_W-1:0]    push_data,
   input  logic [prf_pkg::NB_W-1:0]      push_bytes,
   output prf_pkg::pack_stat_type        stat,
   output prf_pkg::word_wr_type          word_wr
);

   localparam int unsigned DW = prf_pkg::DATA_W;
   localparam int unsigned LW = prf_pkg::LEN_W;
   localparam int unsigned NW = prf_pkg::NB_W;
   localparam logic [LW-1:0] CAP = LW'(SLOT_BYTES);
   localparam logic [NW-1:0] FULL_BEAT = NW'(prf_pkg::BYTES_PER_WORD);

   logic [LW-1:0]   len_ff,      len_in;
   logic            too_long_ff, too_long_in;
   logic [DW-1:0]   tail_ff,     tail_in;

   logic [NW-1:0]   nb;
   logic [LW-1:0]   room;
   logic            over;
   logic [NW-1:0]   take;
   logic [2:0]      offset;
   logic [2*DW-1:0] shifted;
   logic [2*DW-1:0] merged;
   logic            full_word;

   always_comb begin
      nb        = (push_bytes > FULL_BEAT) ? FULL_BEAT : push_bytes;
      room      = CAP - len_ff;
      over      = LW'(nb) > room;
      take      = over ? room[NW-1:0] : nb;
      offset    = len_ff[2:0];
      shifted   = {DW'(0), push_data & prf_pkg::byte_mask(take)} << {offset, 3'b000};
      merged    = {DW'(0), tail_ff} | shifted;
      full_word = (NW'(offset) + take) >= FULL_BEAT;

      stat.length   = len_ff + LW'(take);
      stat.too_long = too_long_ff | over;
      stat.tail     = full_word ? merged[2*DW-1:DW] : merged[DW-1:0];

      word_wr.en    = push_en & full_word;
      word_wr.index = len_ff[LW-1:3];
      word_wr.word  = merged[DW-1:0];

      len_in      = len_ff;
      too_long_in = too_long_ff;
      tail_in     = tail_ff;
      if (drop) begin
         len_in      = '0;
         too_long_in = 1'b0;
         tail_in     = '0;
      end else if (push_en) begin
         len_in      = stat.length;
         too_long_in = stat.too_long;
         tail_in     = stat.tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         too_long_ff <= 1'b0;
         tail_ff     <= '0;
      end else begin
         len_ff      <= len_in;
         too_long_ff <= too_long_in;
         tail_ff     <= tail_in;
      end
   end

endmodule

// File: src/packet_ring_fifo.sv
// ---------------------------------------------------------------------------
// packet_ring_fifo
// ring of fixed-size packet slots with staged push, streamed pop and
// overrun / underrun accounting
// ---------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   -------------------------  --------------------------------
//  request   req_*                      taken when start & !busy
//  result    rsp_*                      one cycle, marked by rsp_valid
//  config    csr_wr_en, csr_wr_data     written when csr_wr_en
//
//  push beat that is not last: no result, busy stays low
//  push last / clear / reject / overrun / underrun: result in the cycle after
//    the beat; a commit then holds busy while the staged words are copied
//    into the slot through the word ram ports
//  pop: busy until the last word is in the result registers; one length
//    ram read, then one word ram read per cycle, a result beat per word
//  reset is synchronous; the receiver cannot stall, no clearing pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_ring_fifo_defines.svh"

module packet_ring_fifo #(
   parameter int unsigned SLOT_COUNT = prf_pkg::SLOT_COUNT_DEF,
   parameter int unsigned SLOT_BYTES = prf_pkg::SLOT_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request beat
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_type,
   input  logic [prf_pkg::DATA_W-1:0] req_push_data,
   input  logic [prf_pkg::NB_W-1:0]   req_push_bytes,
   input  logic                       req_push_last,
   input  logic                       req_packet_ok,
   // result beat
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [prf_pkg::DATA_W-1:0] rsp_pop_data,
   output logic [prf_pkg::NB_W-1:0]   rsp_pop_bytes,
   output logic                       rsp_last,
   output logic                       rsp_silence,
   output logic [prf_pkg::LEN_W-1:0]  rsp_packet_length,
   output logic [3:0]                 rsp_fill_level,
   output logic [prf_pkg::CNT_W-1:0]  rsp_overrun_total,
   output logic [prf_pkg::CNT_W-1:0]  rsp_underrun_total,
   // config
   input  logic                       csr_wr_en,
   input  logic [prf_pkg::MIN_W-1:0]  csr_wr_data
);

   localparam int unsigned DW        = prf_pkg::DATA_W;
   localparam int unsigned LW        = prf_pkg::LEN_W;
   localparam int unsigned NW        = prf_pkg::NB_W;
   localparam int unsigned CW        = prf_pkg::CNT_W;
   localparam int unsigned KW        = prf_pkg::WCNT_W;
   localparam int unsigned WPS       = (SLOT_BYTES + 7) / 8;
   localparam int unsigned SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int unsigned FW        = $clog2(SLOT_COUNT + 1);
   localparam int unsigned WW        = (WPS > 1) ? $clog2(WPS) : 1;
   localparam int unsigned MEM_DEPTH = (SLOT_COUNT + 1) * WPS;
   localparam int unsigned MAW       = $clog2(MEM_DEPTH);

   localparam logic [SW-1:0]  LAST_SLOT  = SW'(SLOT_COUNT - 1);
   localparam logic [FW-1:0]  FULL_LEVEL = FW'(SLOT_COUNT);
   localparam logic [MAW-1:0] WPS_A      = MAW'(WPS);
   localparam logic [MAW-1:0] STAGE_BASE = MAW'(SLOT_COUNT * WPS);
   localparam logic [NW-1:0]  FULL_BEAT  = NW'(prf_pkg::BYTES_PER_WORD);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_POP_LEN,
      ST_POP_RUN
   } state_type;

   // packets held for a given pair of ring pointers
   function automatic logic [FW-1:0] level(input logic [SW-1:0] ws, input logic ww,
                                           input logic [SW-1:0] rs, input logic rw);
      logic [FW-1:0] d;
      d = FW'(ws) - FW'(rs);
      return (ww == rw) ? d : FULL_LEVEL + d;
   endfunction

   // control state
   state_type        state_ff,    state_in;
   logic [prf_pkg::MIN_W-1:0] min_bytes_ff, min_bytes_in;
   logic [SW-1:0]    wr_slot_ff,  wr_slot_in;
   logic             wr_wrap_ff,  wr_wrap_in;
   logic [SW-1:0]    rd_slot_ff,  rd_slot_in;
   logic             rd_wrap_ff,  rd_wrap_in;
   logic [CW-1:0]    ovr_cnt_ff,  ovr_cnt_in;
   logic [CW-1:0]    udr_cnt_ff,  udr_cnt_in;
   logic [KW-1:0]    rd_idx_ff,   rd_idx_in;    // next word to read
   logic             dv_ff,       dv_in;        // word ram data valid
   logic             rsp_valid_ff, rsp_valid_in;

   // transfer payload
   logic [SW-1:0]    xfer_slot_ff, xfer_slot_in;
   logic [LW-1:0]    xfer_len_ff,  xfer_len_in;
   logic [DW-1:0]    xfer_tail_ff, xfer_tail_in;
   logic [KW-1:0]    dv_idx_ff,    dv_idx_in;

   // result payload
   logic [1:0]       rsp_status_ff,         rsp_status_in;
   logic [DW-1:0]    rsp_pop_data_ff,       rsp_pop_data_in;
   logic [NW-1:0]    rsp_pop_bytes_ff,      rsp_pop_bytes_in;
   logic             rsp_last_ff,           rsp_last_in;
   logic             rsp_silence_ff,        rsp_silence_in;
   logic [LW-1:0]    rsp_packet_length_ff,  rsp_packet_length_in;
   logic [3:0]       rsp_fill_level_ff,     rsp_fill_level_in;
   logic [CW-1:0]    rsp_overrun_total_ff,  rsp_overrun_total_in;
   logic [CW-1:0]    rsp_underrun_total_ff, rsp_underrun_total_in;

   // word ram: slots 0..SLOT_COUNT-1 then the staging area
   logic             mem_we, mem_re;
   logic [MAW-1:0]   mem_waddr, mem_raddr;
   logic [DW-1:0]    mem_wdata, mem_rdata;

   // slot length ram
   logic             len_we, len_re;
   logic [SW-1:0]    len_waddr, len_raddr;
   logic [LW-1:0]    len_wdata, len_rdata;

   // packer
   logic                   pack_push, pack_drop;
   prf_pkg::pack_stat_type pack_stat;
   prf_pkg::word_wr_type   pack_wr;

   logic             accept;
   logic [FW-1:0]    fill;
   logic [KW-1:0]    words;
   logic             tail_word;
   logic [LW-1:0]    remain;
   logic [NW-1:0]    beat_bytes;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign fill   = level(wr_slot_ff, wr_wrap_ff, rd_slot_ff, rd_wrap_ff);

   // words in the packet under transfer, and whether its last word is partial
   assign words     = xfer_len_ff[LW-1:3] + KW'(|xfer_len_ff[2:0]);
   assign tail_word = (dv_idx_ff == xfer_len_ff[LW-1:3]) & (|xfer_len_ff[2:0]);
   assign remain    = xfer_len_ff - {dv_idx_ff, 3'b000};
   assign beat_bytes = (remain > LW'(FULL_BEAT)) ? FULL_BEAT : remain[NW-1:0];

   prf_pack #(
      .SLOT_BYTES (SLOT_BYTES)
   ) u_pack (
      .clock      (clock),
      .reset      (reset),
      .push_en    (pack_push),
      .drop       (pack_drop),
      .push_data  (req_push_data),
      .push_bytes (req_push_bytes),
      .stat       (pack_stat),
      .word_wr    (pack_wr)
   );

   prf_ram #(
      .WIDTH (DW),
      .DEPTH (MEM_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   prf_ram #(
      .WIDTH (LW),
      .DEPTH (SLOT_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      min_bytes_in  = csr_wr_en ? csr_wr_data : min_bytes_ff;
      wr_slot_in    = wr_slot_ff;
      wr_wrap_in    = wr_wrap_ff;
      rd_slot_in    = rd_slot_ff;
      rd_wrap_in    = rd_wrap_ff;
      ovr_cnt_in    = ovr_cnt_ff;
      udr_cnt_in    = udr_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      dv_in         = 1'b0;
      dv_idx_in     = rd_idx_ff;
      xfer_slot_in  = xfer_slot_ff;
      xfer_len_in   = xfer_len_ff;
      xfer_tail_in  = xfer_tail_ff;

      rsp_valid_in          = 1'b0;
      rsp_status_in         = prf_pkg::STATUS_OK;
      rsp_pop_data_in       = '0;
      rsp_pop_bytes_in      = '0;
      rsp_last_in           = 1'b0;
      rsp_silence_in        = 1'b0;
      rsp_packet_length_in  = '0;

      pack_push = 1'b0;
      pack_drop = 1'b0;

      // staged words go straight into the staging area
      mem_we    = pack_wr.en;
      mem_waddr = STAGE_BASE + MAW'(pack_wr.index[WW-1:0]);
      mem_wdata = pack_wr.word;
      mem_re    = 1'b0;
      mem_raddr = MAW'(xfer_slot_ff) * WPS_A + MAW'(rd_idx_ff[WW-1:0]);

      len_we    = 1'b0;
      len_waddr = wr_slot_ff;
      len_wdata = pack_stat.length;
      len_re    = 1'b0;
      len_raddr = rd_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  prf_pkg::REQ_PUSH: begin
                     pack_push = 1'b1;
                     if (req_push_last) begin
                        pack_drop    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                        if (pack_stat.length <= LW'(min_bytes_ff) || pack_stat.too_long ||
                            !req_packet_ok) begin
                           rsp_status_in = prf_pkg::STATUS_REJECT;
                        end else if (fill == FULL_LEVEL) begin
                           rsp_status_in = prf_pkg::STATUS_OVERRUN;
                           ovr_cnt_in    = ovr_cnt_ff + CW'(1);
                        end else begin
                           // commit: note length, advance, then copy staging
                           rsp_packet_length_in = pack_stat.length;
                           len_we       = 1'b1;
                           xfer_slot_in = wr_slot_ff;
                           xfer_len_in  = pack_stat.length;
                           xfer_tail_in = pack_stat.tail;
                           rd_idx_in    = '0;
                           wr_slot_in   = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + SW'(1);
                           wr_wrap_in   = wr_wrap_ff ^ (wr_slot_ff == LAST_SLOT);
                           state_in     = ST_COPY;
                        end
                     end
                  end
                  prf_pkg::REQ_POP: begin
                     if (fill == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_last_in    = 1'b1;
                        rsp_silence_in = 1'b1;
                        rsp_status_in  = prf_pkg::STATUS_UNDERRUN;
                        udr_cnt_in     = udr_cnt_ff + CW'(1);
                     end else begin
                        len_re       = 1'b1;
                        xfer_slot_in = rd_slot_ff;
                        rd_slot_in   = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + SW'(1);
                        rd_wrap_in   = rd_wrap_ff ^ (rd_slot_ff == LAST_SLOT);
                        state_in     = ST_POP_LEN;
                     end
                  end
                  prf_pkg::REQ_CLEAR: begin
                     pack_drop    = 1'b1;
                     wr_slot_in   = '0;
                     wr_wrap_in   = 1'b0;
                     rd_slot_in   = '0;
                     rd_wrap_in   = 1'b0;
                     ovr_cnt_in   = '0;
                     udr_cnt_in   = '0;
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                     // unused request code: no result
                  end
               endcase
            end
         end

         ST_COPY: begin
            // read staging word k while word k-1 lands in the slot
            mem_raddr = STAGE_BASE + MAW'(rd_idx_ff[WW-1:0]);
            if (rd_idx_ff < words) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + KW'(1);
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = MAW'(xfer_slot_ff) * WPS_A + MAW'(dv_idx_ff[WW-1:0]);
               mem_wdata = tail_word ? xfer_tail_ff : mem_rdata;
               if (dv_idx_ff == words - KW'(1)) begin
                  dv_in    = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_POP_LEN: begin
            // length is back; first word read goes out now
            xfer_len_in = len_rdata;
            mem_re      = 1'b1;
            mem_raddr   = MAW'(xfer_slot_ff) * WPS_A;
            rd_idx_in   = KW'(1);
            dv_in       = 1'b1;
            dv_idx_in   = '0;
            state_in    = ST_POP_RUN;
         end

         ST_POP_RUN: begin
            if (rd_idx_ff < words) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + KW'(1);
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_pop_data_in      = mem_rdata & prf_pkg::byte_mask(beat_bytes);
               rsp_pop_bytes_in     = beat_bytes;
               rsp_packet_length_in = xfer_len_ff;
               if (dv_idx_ff == words - KW'(1)) begin
                  rsp_last_in = 1'b1;
                  dv_in       = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // occupancy and counters as they stand after this request
      rsp_fill_level_in     = 4'(level(wr_slot_in, wr_wrap_in, rd_slot_in, rd_wrap_in));
      rsp_overrun_total_in  = ovr_cnt_in;
      rsp_underrun_total_in = udr_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_bytes_ff <= prf_pkg::MIN_BYTES_RST;
         wr_slot_ff   <= '0;
         wr_wrap_ff   <= 1'b0;
         rd_slot_ff   <= '0;
         rd_wrap_ff   <= 1'b0;
         ovr_cnt_ff   <= '0;
         udr_cnt_ff   <= '0;
         rd_idx_ff    <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_bytes_ff <= min_bytes_in;
         wr_slot_ff   <= wr_slot_in;
         wr_wrap_ff   <= wr_wrap_in;
         rd_slot_ff   <= rd_slot_in;
         rd_wrap_ff   <= rd_wrap_in;
         ovr_cnt_ff   <= ovr_cnt_in;
         udr_cnt_ff   <= udr_cnt_in;
         rd_idx_ff    <= rd_idx_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xfer_slot_ff          <= xfer_slot_in;
      xfer_len_ff           <= xfer_len_in;
      xfer_tail_ff          <= xfer_tail_in;
      dv_idx_ff             <= dv_idx_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_pop_data_ff       <= rsp_pop_data_in;
      rsp_pop_bytes_ff      <= rsp_pop_bytes_in;
      rsp_last_ff           <= rsp_last_in;
      rsp_silence_ff        <= rsp_silence_in;
      rsp_packet_length_ff  <= rsp_packet_length_in;
      rsp_fill_level_ff     <= rsp_fill_level_in;
      rsp_overrun_total_ff  <= rsp_overrun_total_in;
      rsp_underrun_total_ff <= rsp_underrun_total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pop_data       = rsp_pop_data_ff;
   assign rsp_pop_bytes      = rsp_pop_bytes_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_silence        = rsp_silence_ff;
   assign rsp_packet_length  = rsp_packet_length_ff;
   assign rsp_fill_level     = rsp_fill_level_ff;
   assign rsp_overrun_total  = rsp_overrun_total_ff;
   assign rsp_underrun_total = rsp_underrun_total_ff;

   // ring never holds more than its slots
   `PRF_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill <= FULL_LEVEL)
   // a commit is acknowledged with a nonzero length
   `PRF_ASSERT_NXT(a_commit_ack, clock, reset, state_ff == ST_IDLE && state_in == ST_COPY, rsp_valid_ff && rsp_status_ff == prf_pkg::STATUS_OK && rsp_packet_length_ff != '0)
   // pop on an empty ring answers with silence in the registered result
   `PRF_ASSERT_NXT(a_underrun, clock, reset, accept && req_type == prf_pkg::REQ_POP && fill == '0, rsp_valid_ff && rsp_silence_ff && rsp_last_ff)
   // popping never writes the word ram
   `PRF_ASSERT_IMP(a_pop_no_write, clock, reset, state_ff == ST_POP_LEN || state_ff == ST_POP_RUN, !mem_we)
   // every pop run cycle carries a word
   `PRF_ASSERT_IMP(a_pop_data, clock, reset, state_ff == ST_POP_RUN, dv_ff)

endmodule

// File: dv/packet_ring_fifo_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_ring_fifo_test
// self-checking bench for the packet ring: request beats come from a backlog
// queue through a clocked driver, and every result beat is checked against
// a cycle-free copy of the ring that is advanced on each accepted request
// ---------------------------------------------------------------------------

module packet_ring_fifo_test;

   import prf_pkg::*;

   localparam int unsigned RING_SLOTS  = SLOT_COUNT_DEF;
   localparam int unsigned RING_BYTES  = SLOT_BYTES_DEF;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;  // decoded by nobody, no result
   localparam int          DRAIN_WAIT  = 80;    // longest slot copy plus margin
   localparam int          IDLE_PCT    = 36;

   // one request beat as it goes onto the pins
   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] data;
      logic [NB_W-1:0]   nbytes;
      logic              last;
      logic              ok;
   } req_beat_t;

   // one result beat, field for field with the rsp_ ports
   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data;
      logic [NB_W-1:0]   nbytes;
      logic              last;
      logic              silence;
      logic [LEN_W-1:0]  length;
      logic [3:0]        fill;
      logic [CNT_W-1:0]  overruns;
      logic [CNT_W-1:0]  underruns;
   } rsp_beat_t;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // dut pins, inputs all known from time zero
   logic              start          = 1'b0;
   logic              busy;
   logic [1:0]        req_type       = REQ_PUSH;
   logic [DATA_W-1:0] req_push_data  = '0;
   logic [NB_W-1:0]   req_push_bytes = '0;
   logic              req_push_last  = 1'b0;
   logic              req_packet_ok  = 1'b0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [DATA_W-1:0] rsp_pop_data;
   logic [NB_W-1:0]   rsp_pop_bytes;
   logic              rsp_last;
   logic              rsp_silence;
   logic [LEN_W-1:0]  rsp_packet_length;
   logic [3:0]        rsp_fill_level;
   logic [CNT_W-1:0]  rsp_overrun_total;
   logic [CNT_W-1:0]  rsp_underrun_total;
   logic              csr_wr_en      = 1'b0;
   logic [MIN_W-1:0]  csr_wr_data    = '0;

   packet_ring_fifo i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_push_data      (req_push_data),
      .req_push_bytes     (req_push_bytes),
      .req_push_last      (req_push_last),
      .req_packet_ok      (req_packet_ok),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_pop_data       (rsp_pop_data),
      .rsp_pop_bytes      (rsp_pop_bytes),
      .rsp_last           (rsp_last),
      .rsp_silence        (rsp_silence),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_overrun_total  (rsp_overrun_total),
      .rsp_underrun_total (rsp_underrun_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // bench bookkeeping
   req_beat_t req_backlog[$];   // beats not yet on the pins
   rsp_beat_t due_rsp[$];       // predicted result beats, oldest first
   logic      took      = 1'b0; // last edge took the beat on the pins
   logic      steady    = 1'b0; // no random idling while set
   int        beats_queued = 0;
   int        errors    = 0;
   int        n_rsp     = 0;
   int        n_commit  = 0;
   int        n_reject  = 0;
   int        n_overrun = 0;
   int        n_underrun = 0;

   // shadow copy of the ring
   logic [7:0]       slot_bytes [RING_SLOTS][RING_BYTES];
   int               slot_len   [RING_SLOTS];
   logic [7:0]       stage_bytes [RING_BYTES];
   int               stage_len  = 0;
   logic             stage_long = 1'b0;
   logic [3:0]       wr_seq     = '0;   // sequences run modulo twice the slot count
   logic [3:0]       rd_seq     = '0;
   logic [CNT_W-1:0] overrun_cnt  = '0;
   logic [CNT_W-1:0] underrun_cnt = '0;
   logic [MIN_W-1:0] min_bytes  = MIN_BYTES_RST;

   // stamp the shared fields and queue one predicted beat
   task automatic post_rsp(input rsp_beat_t r);
      r.fill      = 4'(wr_seq - rd_seq);
      r.overruns  = overrun_cnt;
      r.underruns = underrun_cnt;
      due_rsp.push_back(r);
   endtask

   // advance the shadow ring by one accepted request beat
   task automatic ring_step(input req_beat_t b);
      rsp_beat_t r;
      int        nb;
      int        words;
      int        len;
      int        slot;
      r      = '0;
      r.last = 1'b1;
      case (b.kind)
         REQ_PUSH: begin
            nb = (b.nbytes > 8) ? 8 : int'(b.nbytes);
            for (int i = 0; i < nb; i++) begin
               if (stage_len < RING_BYTES) begin
                  stage_bytes[stage_len] = b.data[8*i +: 8];
                  stage_len++;
               end else begin
                  // bytes past the slot are dropped, packet marked too long
                  stage_long = 1'b1;
               end
            end
            if (b.last) begin
               if (stage_len <= int'(min_bytes) || stage_long || !b.ok) begin
                  r.status = STATUS_REJECT;
               end else if (4'(wr_seq - rd_seq) >= RING_SLOTS) begin
                  overrun_cnt++;
                  r.status = STATUS_OVERRUN;
               end else begin
                  slot = int'(wr_seq) % RING_SLOTS;
                  for (int i = 0; i < stage_len; i++) begin
                     slot_bytes[slot][i] = stage_bytes[i];
                  end
                  slot_len[slot] = stage_len;
                  wr_seq++;
                  r.status = STATUS_OK;
                  r.length = LEN_W'(stage_len);
               end
               stage_len  = 0;
               stage_long = 1'b0;
               post_rsp(r);
            end
         end
         REQ_POP: begin
            if (wr_seq == rd_seq) begin
               underrun_cnt++;
               r.status  = STATUS_UNDERRUN;
               r.silence = 1'b1;
               post_rsp(r);
            end else begin
               slot = int'(rd_seq) % RING_SLOTS;
               len  = slot_len[slot];
               rd_seq++;
               words = (len + 7) / 8;
               if (words == 0) begin
                  post_rsp(r);
               end
               for (int w = 0; w < words; w++) begin
                  nb       = (len - 8*w > 8) ? 8 : len - 8*w;
                  r.data   = '0;
                  for (int i = 0; i < nb; i++) begin
                     r.data[8*i +: 8] = slot_bytes[slot][8*w + i];
                  end
                  r.status = STATUS_OK;
                  r.nbytes = NB_W'(nb);
                  r.last   = (w == words - 1);
                  r.length = LEN_W'(len);
                  post_rsp(r);
               end
            end
         end
         REQ_CLEAR: begin
            wr_seq       = '0;
            rd_seq       = '0;
            overrun_cnt  = '0;
            underrun_cnt = '0;
            stage_len    = 0;
            stage_long   = 1'b0;
            post_rsp(r);
         end
         default: begin
            // unused request code, ignored by the ring
         end
      endcase
   endtask

   // note the beat taken at this edge and predict what it causes
   always @(posedge clock) begin
      took <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         ring_step('{kind: req_type, data: req_push_data, nbytes: req_push_bytes,
                     last: req_push_last, ok: req_packet_ok});
      end
   end

   // driver: hold a beat until taken, else maybe idle, else next backlog beat
   always @(negedge clock) begin
      req_beat_t b;
      if (reset || (start && !took)) begin
         // beat still waiting on the pins
      end else if (req_backlog.size() != 0 &&
                   (steady || $urandom_range(99) >= IDLE_PCT)) begin
         b = req_backlog.pop_front();
         start          <= 1'b1;
         req_type       <= b.kind;
         req_push_data  <= b.data;
         req_push_bytes <= b.nbytes;
         req_push_last  <= b.last;
         req_packet_ok  <= b.ok;
      end else begin
         // idle cycle, payload pins carry junk
         start          <= 1'b0;
         req_type       <= 2'($urandom);
         req_push_data  <= {$urandom, $urandom};
         req_push_bytes <= NB_W'($urandom);
         req_push_last  <= 1'($urandom);
         req_packet_ok  <= 1'($urandom);
      end
   end

   task automatic report(input string what);
      errors++;
      if (errors <= 25) begin
         $display("mismatch at %0t ns: %s", $realtime, what);
      end
   endtask

   // monitor: every result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_beat_t got;
      rsp_beat_t want;
      if (!reset && rsp_valid) begin
         got = '{status: rsp_status, data: rsp_pop_data, nbytes: rsp_pop_bytes,
                 last: rsp_last, silence: rsp_silence, length: rsp_packet_length,
                 fill: rsp_fill_level, overruns: rsp_overrun_total,
                 underruns: rsp_underrun_total};
         if (due_rsp.size() == 0) begin
            report($sformatf("result beat with nothing outstanding, status %0d",
                             got.status));
         end else begin
            want = due_rsp.pop_front();
            n_rsp++;
            if (want.status == STATUS_REJECT) n_reject++;
            if (want.status == STATUS_OVERRUN) n_overrun++;
            if (want.status == STATUS_UNDERRUN) n_underrun++;
            if (want.status == STATUS_OK && want.nbytes == 0 && want.length != 0) begin
               n_commit++;
            end
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.data !== want.data)
               report($sformatf("pop_data %h, want %h", got.data, want.data));
            if (got.nbytes !== want.nbytes)
               report($sformatf("pop_bytes %0d, want %0d", got.nbytes, want.nbytes));
            if (got.last !== want.last)
               report($sformatf("last %b, want %b", got.last, want.last));
            if (got.silence !== want.silence)
               report($sformatf("silence %b, want %b", got.silence, want.silence));
            if (got.length !== want.length)
               report($sformatf("packet_length %0d, want %0d", got.length, want.length));
            if (got.fill !== want.fill)
               report($sformatf("fill_level %0d, want %0d", got.fill, want.fill));
            if (got.overruns !== want.overruns)
               report($sformatf("overrun_total %0d, want %0d", got.overruns,
                                want.overruns));
            if (got.underruns !== want.underruns)
               report($sformatf("underrun_total %0d, want %0d", got.underruns,
                                want.underruns));
         end
      end
   end

   // stimulus helpers
   task automatic add_beat(input logic [1:0] kind, input logic [DATA_W-1:0] data,
                           input int nbytes, input logic last, input logic ok);
      req_backlog.push_back('{kind: kind, data: data, nbytes: NB_W'(nbytes),
                              last: last, ok: ok});
      if (kind != REQ_UNUSED) beats_queued++;
   endtask

   // one packet of push beats; negative width picks a random byte count per beat
   task automatic add_packet(input int nbeats, input int width, input logic ok);
      int nb;
      for (int k = 0; k < nbeats; k++) begin
         if (width >= 0) nb = width;
         else nb = ($urandom_range(3) != 0) ? 8 : $urandom_range(15);
         add_beat(REQ_PUSH, {$urandom, $urandom}, nb, k == nbeats - 1,
                  (k == nbeats - 1) ? ok : 1'($urandom));
      end
   endtask

   // non-push beat with junk in the push fields
   task automatic add_ctrl(input logic [1:0] kind);
      add_beat(kind, {$urandom, $urandom}, $urandom_range(15), 1'($urandom),
               1'($urandom));
   endtask

   // mostly well-formed packets and pops, with clears, runts and junk codes
   task automatic random_phase(input int n, input int push_pct, input int pop_pct);
      int goal;
      int r;
      goal = beats_queued + n;
      while (beats_queued < goal) begin
         r = $urandom_range(99);
         if (r < push_pct) add_packet($urandom_range(1, 5), -1, $urandom_range(99) >= 8);
         else if (r < push_pct + pop_pct) add_ctrl(REQ_POP);
         else if (r < push_pct + pop_pct + 3) add_ctrl(REQ_CLEAR);
         else if (r < push_pct + pop_pct + 5) add_ctrl(REQ_UNUSED);
         else add_packet(1, $urandom_range(0, 3), 1'b1);
      end
   endtask

   // wait for the backlog and all predictions to drain, then for slot copies
   task automatic settle();
      @(posedge clock);
      while (req_backlog.size() != 0 || start || due_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // header size register, written only with the ring idle
   task automatic set_min_bytes(input logic [MIN_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      min_bytes   = v;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_min_bytes(MIN_BYTES_RST);

      // directed: underrun, junk code, header-length reject, odd byte counts,
      // validator reject, multi-word pop, data extremes, clear, empty packet
      add_ctrl(REQ_POP);
      add_ctrl(REQ_UNUSED);
      add_packet(2, 8, 1'b1);                       // exactly the header size
      add_beat(REQ_PUSH, {$urandom, $urandom}, 0, 1'b0, 1'b0);
      add_beat(REQ_PUSH, {$urandom, $urandom}, 15, 1'b0, 1'b0);
      add_beat(REQ_PUSH, {$urandom, $urandom}, 9, 1'b0, 1'b0);
      add_beat(REQ_PUSH, {$urandom, $urandom}, 1, 1'b1, 1'b1);  // 17 bytes commit
      add_packet(3, 8, 1'b0);                       // validator says no
      add_ctrl(REQ_POP);
      add_beat(REQ_PUSH, '1, 8, 1'b0, 1'b1);
      add_beat(REQ_PUSH, '0, 8, 1'b0, 1'b0);
      add_beat(REQ_PUSH, '1, 8, 1'b1, 1'b1);
      add_ctrl(REQ_CLEAR);
      add_ctrl(REQ_POP);
      add_beat(REQ_PUSH, '1, 0, 1'b1, 1'b1);        // no bytes at all
      add_packet(3, 8, 1'b1);
      add_ctrl(REQ_POP);
      settle();

      // push-heavy run with the sender never idling, ring fills and overruns
      set_min_bytes('0);
      steady = 1'b1;
      random_phase(110, 70, 18);
      settle();
      steady = 1'b0;

      set_min_bytes(MIN_W'($urandom_range(1, 40)));
      random_phase(100, 50, 38);
      settle();

      // pop-heavy run, underruns pile up
      set_min_bytes(9'd8);
      random_phase(90, 30, 58);
      settle();

      // largest sizes: full slot, a 504-byte validator reject and a runt, staging overflow
      set_min_bytes('1);
      add_packet(64, 8, 1'b1);
      add_ctrl(REQ_POP);
      add_packet(63, 8, 1'b0);
      add_beat(REQ_PUSH, {$urandom, $urandom}, 7, 1'b1, 1'b1);
      add_packet(65, 8, 1'b1);
      add_ctrl(REQ_POP);
      settle();

      $display("covered %0d request beats, %0d result beats over five header sizes",
               beats_queued, n_rsp);
      $display("%0d commits, %0d rejects, %0d overruns, %0d underruns",
               n_commit, n_reject, n_overrun, n_underrun);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("watchdog expired with %0d result beats outstanding", due_rsp.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
